@@ hdl/pal_pkg.sv @@
// shared types and constants for the positional array list unit
// no dependencies; used by pal_front, pal_queue, pal_back and the top level
package pal_pkg;

  localparam int unsigned DEPTH   = 64;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IDX_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

  // action codes on the input transaction
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // work for the back end after classification
  typedef enum logic [1:0] {
    OP_NONE   = 2'd0,
    OP_INSERT = 2'd1,
    OP_GET    = 2'd2,
    OP_DELETE = 2'd3
  } op_e;

  // back end sequencer states
  typedef enum logic [2:0] {
    B_IDLE     = 3'd0,
    B_RUN      = 3'd1,
    B_INS_WR   = 3'd2,
    B_GET_WAIT = 3'd3,
    B_DEL_CAP  = 3'd4,
    B_DEL_STEP = 3'd5,
    B_DEL_WR   = 3'd6
  } bstate_e;

  typedef struct packed {
    op_e               op;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
    logic [CNT_W-1:0]  old_len;
    logic [CNT_W-1:0]  new_len;
    status_e           status;
  } cmd_t;

endpackage

@@ hdl/pal_front.sv @@
// front end: accepts transactions, tracks the list length and capacity,
// classifies each action into a command for the back end; uses pal_pkg
module pal_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [1:0]                   action_i,
  input  logic [pal_pkg::IDX_W-1:0]    position_i,
  input  logic [pal_pkg::DATA_W-1:0]   value_i,
  input  logic                         cfg_we_i,
  input  logic [pal_pkg::CNT_W-1:0]    cfg_data_i,
  input  logic                         q_full_i,
  output logic                         busy_o,
  output logic                         push_o,
  output pal_pkg::cmd_t                cmd_o
);

  logic [pal_pkg::CNT_W-1:0] count_q, count_d;
  logic [pal_pkg::CNT_W-1:0] cap_q, cap_d;
  logic [pal_pkg::CNT_W-1:0] eff_cap;
  pal_pkg::action_e          act;

  // length and capacity registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= pal_pkg::CAP_RESET;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  // classify the incoming action
  always_comb begin
    act     = pal_pkg::action_e'(action_i);
    eff_cap = (cap_q > pal_pkg::DEPTH_C) ? pal_pkg::DEPTH_C : cap_q;

    cmd_o.op      = pal_pkg::OP_NONE;
    cmd_o.pos     = position_i;
    cmd_o.value   = value_i;
    cmd_o.old_len = count_q;
    cmd_o.new_len = count_q;
    cmd_o.status  = pal_pkg::ST_OK;

    case (act)
      pal_pkg::ACT_INSERT: begin
        if (count_q >= eff_cap) begin
          cmd_o.status = pal_pkg::ST_FULL;
        end else begin
          cmd_o.op      = pal_pkg::OP_INSERT;
          // past the end appends
          if ({1'b0, position_i} > count_q) begin
            cmd_o.pos = count_q[pal_pkg::IDX_W-1:0];
          end
          cmd_o.new_len = pal_pkg::CNT_W'(count_q + 1'b1);
        end
      end
      pal_pkg::ACT_GET: begin
        if ({1'b0, position_i} >= count_q) begin
          cmd_o.status = pal_pkg::ST_RANGE;
        end else begin
          cmd_o.op = pal_pkg::OP_GET;
        end
      end
      pal_pkg::ACT_DELETE: begin
        if ({1'b0, position_i} >= count_q) begin
          cmd_o.status = pal_pkg::ST_RANGE;
        end else begin
          cmd_o.op      = pal_pkg::OP_DELETE;
          cmd_o.new_len = pal_pkg::CNT_W'(count_q - 1'b1);
        end
      end
      pal_pkg::ACT_CLEAR: begin
        cmd_o.new_len = '0;
      end
      default: begin
        cmd_o.op = pal_pkg::OP_NONE;
      end
    endcase
  end

  // handshake and state update
  assign busy_o  = q_full_i;
  assign push_o  = start_i && !q_full_i;
  assign count_d = push_o ? cmd_o.new_len : count_q;
  assign cap_d   = cfg_we_i ? cfg_data_i : cap_q;

endmodule

@@ hdl/pal_queue.sv @@
// short command queue between front and back end
// depends on pal_pkg for the command type and depth
module pal_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pal_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output pal_pkg::cmd_t cmd_o
);

  pal_pkg::cmd_t              slot_q [pal_pkg::QDEPTH];
  logic [pal_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pal_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pal_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  // pointer and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage slots
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  // next pointers
  always_comb begin
    wr_ptr_d = push_i ? pal_pkg::QPTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = pop_i ? pal_pkg::QPTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = pal_pkg::QCNT_W'(cnt_q + 1'b1);
    end else if (pop_i && !push_i) begin
      cnt_d = pal_pkg::QCNT_W'(cnt_q - 1'b1);
    end
  end

  assign full_o  = (cnt_q == pal_pkg::QCNT_W'(pal_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

endmodule

@@ hdl/pal_back.sv @@
// back end: holds the entry memory and runs each command, shifting
// entries one word at a time; emits the result transaction; uses pal_pkg
module pal_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         q_valid_i,
  input  pal_pkg::cmd_t                q_cmd_i,
  output logic                         q_pop_o,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [pal_pkg::DATA_W-1:0]   data_o,
  output logic [pal_pkg::CNT_W-1:0]    length_o
);

  pal_pkg::bstate_e           state_q, state_d;
  pal_pkg::cmd_t              cmd_q, cmd_d;
  logic [pal_pkg::IDX_W-1:0]  idx_q, idx_d;
  logic [pal_pkg::DATA_W-1:0] held_q, held_d;

  // result register
  logic                       res_vld_q, res_vld_d;
  pal_pkg::status_e           res_st_q, res_st_d;
  logic [pal_pkg::DATA_W-1:0] res_data_q, res_data_d;
  logic [pal_pkg::CNT_W-1:0]  res_len_q, res_len_d;

  // entry memory, one write and one registered read port
  logic [pal_pkg::DATA_W-1:0] mem_q [pal_pkg::DEPTH];
  logic [pal_pkg::DATA_W-1:0] rd_data_q;
  logic                       mem_we;
  logic [pal_pkg::IDX_W-1:0]  mem_waddr;
  logic [pal_pkg::DATA_W-1:0] mem_wdata;
  logic [pal_pkg::IDX_W-1:0]  mem_raddr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[mem_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pal_pkg::B_IDLE;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_vld_q <= res_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    idx_q      <= idx_d;
    held_q     <= held_d;
    res_st_q   <= res_st_d;
    res_data_q <= res_data_d;
    res_len_q  <= res_len_d;
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    idx_d      = idx_q;
    held_d     = held_q;
    q_pop_o    = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = rd_data_q;
    mem_raddr  = idx_q;
    res_vld_d  = 1'b0;
    res_st_d   = cmd_q.status;
    res_data_d = '0;
    res_len_d  = cmd_q.new_len;

    case (state_q)
      pal_pkg::B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          // insert walks down from the old end, delete walks up from pos
          if (q_cmd_i.op == pal_pkg::OP_INSERT) begin
            idx_d = q_cmd_i.old_len[pal_pkg::IDX_W-1:0];
          end else begin
            idx_d = q_cmd_i.pos;
          end
          state_d = pal_pkg::B_RUN;
        end
      end
      pal_pkg::B_RUN: begin
        case (cmd_q.op)
          pal_pkg::OP_INSERT: begin
            if (idx_q != cmd_q.pos) begin
              mem_raddr = pal_pkg::IDX_W'(idx_q - 1'b1);
              state_d   = pal_pkg::B_INS_WR;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = cmd_q.pos;
              mem_wdata = cmd_q.value;
              res_vld_d = 1'b1;
              state_d   = pal_pkg::B_IDLE;
            end
          end
          pal_pkg::OP_GET: begin
            mem_raddr = cmd_q.pos;
            state_d   = pal_pkg::B_GET_WAIT;
          end
          pal_pkg::OP_DELETE: begin
            mem_raddr = cmd_q.pos;
            state_d   = pal_pkg::B_DEL_CAP;
          end
          default: begin
            // refused action or clear: nothing to touch
            res_vld_d = 1'b1;
            state_d   = pal_pkg::B_IDLE;
          end
        endcase
      end
      pal_pkg::B_INS_WR: begin
        // move one word up
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = pal_pkg::IDX_W'(idx_q - 1'b1);
        state_d   = pal_pkg::B_RUN;
      end
      pal_pkg::B_GET_WAIT: begin
        res_vld_d  = 1'b1;
        res_data_d = rd_data_q;
        state_d    = pal_pkg::B_IDLE;
      end
      pal_pkg::B_DEL_CAP: begin
        held_d  = rd_data_q;
        state_d = pal_pkg::B_DEL_STEP;
      end
      pal_pkg::B_DEL_STEP: begin
        if (pal_pkg::CNT_W'({1'b0, idx_q} + 1'b1) < cmd_q.old_len) begin
          mem_raddr = pal_pkg::IDX_W'(idx_q + 1'b1);
          state_d   = pal_pkg::B_DEL_WR;
        end else begin
          res_vld_d  = 1'b1;
          res_data_d = held_q;
          state_d    = pal_pkg::B_IDLE;
        end
      end
      pal_pkg::B_DEL_WR: begin
        // move one word down
        mem_we    = 1'b1;
        mem_waddr = idx_q;
        mem_wdata = rd_data_q;
        idx_d     = pal_pkg::IDX_W'(idx_q + 1'b1);
        state_d   = pal_pkg::B_DEL_STEP;
      end
      default: begin
        state_d = pal_pkg::B_IDLE;
      end
    endcase
  end

  assign done_o   = res_vld_q;
  assign status_o = res_st_q;
  assign data_o   = res_data_q;
  assign length_o = res_len_q;

endmodule

@@ hdl/positional_array_list_unit.sv @@
// positional array list unit: top level joining front end, command queue
// and back end; depends on pal_pkg, pal_front, pal_queue and pal_back
//
// An action is taken when start_i is high and busy_o low; busy_o rises only
// while the two-entry command queue is full. Each action returns one result
// marked by done_o for a single cycle, in order; the result cannot be held
// off. The front end settles status and length at once; the back end owns
// the entry memory (one write port, one registered read port) and moves
// one word at a time, read then write. Insert shifts the entries from
// position to the old end up one place; delete shifts those above position
// down one and returns the removed word. No clearing pass follows reset.
module positional_array_list_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   action_i,
  input  logic [pal_pkg::IDX_W-1:0]    position_i,
  input  logic [pal_pkg::DATA_W-1:0]   value_i,
  input  logic                         cfg_we_i,
  input  logic [pal_pkg::CNT_W-1:0]    cfg_data_i,
  output logic                         done_o,
  output logic [1:0]                   status_o,
  output logic [pal_pkg::DATA_W-1:0]   data_o,
  output logic [pal_pkg::CNT_W-1:0]    length_o
);

  logic          push;
  logic          q_full;
  logic          q_valid;
  logic          q_pop;
  pal_pkg::cmd_t front_cmd;
  pal_pkg::cmd_t q_cmd;

  // classify and count
  pal_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .action_i   (action_i),
    .position_i (position_i),
    .value_i    (value_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .q_full_i   (q_full),
    .busy_o     (busy_o),
    .push_o     (push),
    .cmd_o      (front_cmd)
  );

  // decoupling queue
  pal_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // memory work and result transaction
  pal_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .done_o    (done_o),
    .status_o  (status_o),
    .data_o    (data_o),
    .length_o  (length_o)
  );

endmodule
